@@ src/ffa_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
package ffa_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int UNIT_BYTES_DEF = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY     = 2'd1;
  localparam logic [1:0] ST_BAD_ADDRESS   = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOCATED = 2'd3;

  typedef struct packed {
    logic        op;
    logic [12:0] request_bytes;
    logic [11:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] block_address;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_WR,
    S_F_RD,
    S_F_EV,
    S_F_NRD,
    S_F_NEV,
    S_F_WT,
    S_W_RD,
    S_W_EV,
    S_W_MRG,
    S_W_KILL,
    S_DONE
  } state_t;

endpackage

@@ src/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/first_fit_heap_allocator.sv @@
// First-fit heap allocator with coalescing, headers kept in one RAM.
//
// The heap of HEAP_BYTES is cut into units of UNIT_BYTES (a power of two); each block has a
// one-unit header stored in a header RAM (valid, used, payload size). After reset the block
// runs a clearing pass over every header entry and accepts no word until it ends.
// A request reads and evaluates block headers one at a time: an allocate walks the block
// list from unit 1 until the first fit, a free reads its header and its successor, then
// walks the list up to the freed block to merge with its predecessor. All reads share the
// single RAM read port.
// One result word is produced per request; the next request is accepted while it waits.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF,
  parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffa_pkg::in_word_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ffa_pkg::out_word_t out_data
);

  localparam int UNITS = HEAP_BYTES / UNIT_BYTES;
  localparam int UW    = $clog2(UNITS);
  localparam int EW    = UW + 2;
  localparam int WW    = (UW + 2 > 14) ? UW + 2 : 14;
  localparam int SHIFT = $clog2(UNIT_BYTES);
  localparam int AFW   = WW + SHIFT;

  ffa_pkg::state_t state_r, state_nxt;
  logic [WW-1:0]   h_r, h_nxt;
  logic [WW-1:0]   need_r, need_nxt;
  logic [UW-1:0]   t_r, t_nxt;
  logic [UW-1:0]   tsize_r, tsize_nxt;
  logic [UW-1:0]   prev_r, prev_nxt;
  logic [UW-1:0]   psize_r, psize_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic [11:0]     res_addr_r, res_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  ffa_pkg::out_word_t out_data_r, out_data_nxt;

  logic          ram_we;
  logic [UW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic          rv, ru;
  logic [UW-1:0] rs;
  logic [WW-1:0] rs_w, blk_next, rest, nx_idx;
  logic          fit, split;
  logic [AFW-1:0] pay_addr;
  logic [13:0]   bytes_up;
  logic [16:0]   fa_ext;
  logic          bad_addr;

  ffa_ram #(.WIDTH(EW), .DEPTH(UNITS)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rv       = ram_rdata[EW-1];
  assign ru       = ram_rdata[EW-2];
  assign rs       = ram_rdata[UW-1:0];
  assign rs_w     = WW'(rs);
  assign blk_next = h_r + WW'(1) + rs_w;
  assign rest     = h_r + WW'(1) + need_r;
  assign nx_idx   = WW'(t_r) + WW'(1) + rs_w;
  assign fit      = rv && !ru && (rs_w >= need_r);
  assign split    = rs_w > need_r;
  assign pay_addr = AFW'(h_r + WW'(1)) << SHIFT;
  assign bytes_up = 14'(in_data.request_bytes) + 14'(UNIT_BYTES - 1);
  assign fa_ext   = 17'(in_data.free_address);
  assign bad_addr = (in_data.free_address[SHIFT-1:0] != '0) ||
                    (fa_ext < 17'(2 * UNIT_BYTES)) || (fa_ext >= 17'(HEAP_BYTES));

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    need_nxt      = need_r;
    t_nxt         = t_r;
    tsize_nxt     = tsize_r;
    prev_nxt      = prev_r;
    psize_nxt     = psize_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ffa_pkg::S_CLR: begin
        h_nxt = h_r + WW'(1);
        if (h_r == WW'(UNITS - 1)) begin
          state_nxt = ffa_pkg::S_IDLE;
        end
      end
      ffa_pkg::S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt = '0;
          res_st_nxt   = ffa_pkg::ST_OK;
          h_nxt        = WW'(1);
          if (in_data.op == ffa_pkg::OP_ALLOC) begin
            need_nxt = WW'(bytes_up >> SHIFT);
            if (in_data.request_bytes == '0) begin
              res_st_nxt = ffa_pkg::ST_NO_MEMORY;
              state_nxt  = ffa_pkg::S_DONE;
            end else begin
              state_nxt = ffa_pkg::S_A_RD;
            end
          end else begin
            t_nxt = UW'((WW'(in_data.free_address) >> SHIFT) - WW'(1));
            if (bad_addr) begin
              res_st_nxt = ffa_pkg::ST_BAD_ADDRESS;
              state_nxt  = ffa_pkg::S_DONE;
            end else begin
              state_nxt = ffa_pkg::S_F_RD;
            end
          end
        end
      end
      ffa_pkg::S_A_RD: state_nxt = ffa_pkg::S_A_EV;
      ffa_pkg::S_A_EV: begin
        if (fit) begin
          tsize_nxt    = split ? need_r[UW-1:0] : rs;
          res_addr_nxt = pay_addr[11:0];
          state_nxt    = ffa_pkg::S_A_WR;
        end else if (!rv) begin
          res_st_nxt = ffa_pkg::ST_NO_MEMORY;
          state_nxt  = ffa_pkg::S_DONE;
        end else begin
          h_nxt = blk_next;
          if (blk_next >= WW'(UNITS)) begin
            res_st_nxt = ffa_pkg::ST_NO_MEMORY;
            state_nxt  = ffa_pkg::S_DONE;
          end else begin
            state_nxt = ffa_pkg::S_A_RD;
          end
        end
      end
      ffa_pkg::S_A_WR: state_nxt = ffa_pkg::S_DONE;
      ffa_pkg::S_F_RD: state_nxt = ffa_pkg::S_F_EV;
      ffa_pkg::S_F_EV: begin
        if (!rv || !ru) begin
          res_st_nxt = ffa_pkg::ST_NOT_ALLOCATED;
          state_nxt  = ffa_pkg::S_DONE;
        end else begin
          tsize_nxt = rs;
          h_nxt     = nx_idx;
          state_nxt = (nx_idx < WW'(UNITS)) ? ffa_pkg::S_F_NRD : ffa_pkg::S_F_WT;
        end
      end
      ffa_pkg::S_F_NRD: state_nxt = ffa_pkg::S_F_NEV;
      ffa_pkg::S_F_NEV: begin
        if (rv && !ru) begin
          tsize_nxt = tsize_r + UW'(1) + rs;
        end
        state_nxt = ffa_pkg::S_F_WT;
      end
      ffa_pkg::S_F_WT: begin
        h_nxt     = WW'(1);
        state_nxt = (t_r == UW'(1)) ? ffa_pkg::S_DONE : ffa_pkg::S_W_RD;
      end
      ffa_pkg::S_W_RD: state_nxt = ffa_pkg::S_W_EV;
      ffa_pkg::S_W_EV: begin
        if (!rv) begin
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          prev_nxt  = h_r[UW-1:0];
          psize_nxt = rs;
          h_nxt     = blk_next;
          if (blk_next < WW'(UNITS) && blk_next != WW'(t_r)) begin
            state_nxt = ffa_pkg::S_W_RD;
          end else if (blk_next == WW'(t_r) && !ru) begin
            state_nxt = ffa_pkg::S_W_MRG;
          end else begin
            state_nxt = ffa_pkg::S_DONE;
          end
        end
      end
      ffa_pkg::S_W_MRG:  state_nxt = ffa_pkg::S_W_KILL;
      ffa_pkg::S_W_KILL: state_nxt = ffa_pkg::S_DONE;
      ffa_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_st_r;
          out_data_nxt.block_address = res_addr_r;
          state_nxt                  = ffa_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // RAM access and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = h_r[UW-1:0];
    ram_wdata = '0;
    ram_raddr = (state_r == ffa_pkg::S_F_RD) ? t_r : h_r[UW-1:0];
    in_ready  = (state_r == ffa_pkg::S_IDLE);
    unique case (state_r)
      ffa_pkg::S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = (h_r == WW'(1)) ? {2'b10, UW'(UNITS - 2)} : '0;
      end
      ffa_pkg::S_A_EV: begin
        // split off the spare units as a new free block
        ram_we    = fit && split && (rest < WW'(UNITS));
        ram_waddr = rest[UW-1:0];
        ram_wdata = {2'b10, UW'(rs_w - need_r - WW'(1))};
      end
      ffa_pkg::S_A_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {2'b11, tsize_r};
      end
      ffa_pkg::S_F_NEV: begin
        ram_we = rv && !ru;
      end
      ffa_pkg::S_F_WT: begin
        ram_we    = 1'b1;
        ram_waddr = t_r;
        ram_wdata = {2'b10, tsize_r};
      end
      ffa_pkg::S_W_MRG: begin
        ram_we    = 1'b1;
        ram_waddr = prev_r;
        ram_wdata = {2'b10, UW'(psize_r + UW'(1) + tsize_r)};
      end
      ffa_pkg::S_W_KILL: begin
        ram_we    = 1'b1;
        ram_waddr = t_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::S_CLR;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r     <= need_nxt;
    t_r        <= t_nxt;
    tsize_r    <= tsize_nxt;
    prev_r     <= prev_nxt;
    psize_r    <= psize_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ src/ffa_check.sv @@
// Port-level checker for the allocator, bound to the top level.
module ffa_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ffa_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ffa_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ffa_pkg::ST_OK |-> out_data.block_address == '0)
    else $error("failed request reports an address");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || !$rose(out_valid))
    else $error("result word appears in the cycle after its request");

endmodule

bind first_fit_heap_allocator ffa_check u_ffa_check (.*);
